[hw/rtl/btf_pkg.sv]
// Shared types and codes for the budget-limited task FIFO.
`timescale 1ns / 1ps

package btf_pkg;

  localparam int DUR_W    = 16;
  localparam int STATUS_W = 3;

  // Request codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_EXEC = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVER_BUDGET = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EXECUTED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd4;

  localparam logic [DUR_W-1:0] TIME_LIMIT_RESET = 16'd300;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;      // capture the incoming request
    logic commit_direct; // resolve an add or an empty execute into the result slot
    logic rd_issue;      // read the oldest entry
    logic commit_pop;    // retire the entry that was read
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic req_exec;  // held request is an execute
    logic q_empty;   // no entry queued
    logic out_free;  // result slot can take a result this cycle
  } dp_stat_t;

endpackage

[hw/rtl/btf_ctrl.sv]
// Request sequencer for the budget-limited task FIFO.
`timescale 1ns / 1ps

module btf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  btf_pkg::dp_stat_t st,
  output btf_pkg::dp_cmd_t  cmd
);
  import btf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (st.req_exec && !st.q_empty) begin
          cmd.rd_issue = 1'b1;
          state_next   = S_READ;
        end else if (st.out_free) begin
          cmd.commit_direct = 1'b1;
          state_next        = S_IDLE;
        end
      end
      S_READ: begin
        if (st.out_free) begin
          cmd.commit_pop = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/btf_datapath.sv]
// Task store, pointers, budget accounting and result register.
`timescale 1ns / 1ps

module btf_datapath #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [btf_pkg::DUR_W-1:0]           cfg_data,
  input  logic                                cmd,
  input  logic [btf_pkg::DUR_W-1:0]           duration,
  input  btf_pkg::dp_cmd_t                    ctl,
  output btf_pkg::dp_stat_t                   st,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [btf_pkg::STATUS_W-1:0]        status,
  output logic [btf_pkg::DUR_W-1:0]           task_time,
  output logic [btf_pkg::DUR_W-1:0]           time_used
);
  import btf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [DUR_W-1:0] task_store [QUEUE_DEPTH];
  logic [DUR_W-1:0] rd_data;

  logic             req_cmd;
  logic [DUR_W-1:0] req_dur;
  logic [DUR_W-1:0] time_limit;
  logic [PTR_W-1:0] head_ptr;
  logic [PTR_W-1:0] tail_ptr;
  logic [CNT_W-1:0] occupancy;
  logic [DUR_W-1:0] used_time;

  logic             over_budget;
  logic             q_full;
  logic             wr_en;
  logic [DUR_W-1:0] used_next;
  logic [STATUS_W-1:0] status_next;
  logic [DUR_W-1:0] task_next;
  logic             commit;

  assign over_budget = ({1'b0, used_time} + {1'b0, req_dur}) > {1'b0, time_limit};
  assign q_full      = (occupancy == CNT_FULL);
  assign wr_en       = ctl.commit_direct && (req_cmd == CMD_ADD) && !over_budget && !q_full;
  assign commit      = ctl.commit_direct || ctl.commit_pop;

  assign st.req_exec = (req_cmd == CMD_EXEC);
  assign st.q_empty  = (occupancy == '0);
  assign st.out_free = !out_valid || out_ready;

  always_comb begin
    used_next   = used_time;
    task_next   = '0;
    status_next = ST_EMPTY;
    if (ctl.commit_pop) begin
      used_next   = used_time - rd_data;
      task_next   = rd_data;
      status_next = ST_EXECUTED;
    end else if (req_cmd == CMD_ADD) begin
      if (over_budget) begin
        status_next = ST_OVER_BUDGET;
      end else if (q_full) begin
        status_next = ST_FULL;
      end else begin
        used_next   = used_time + req_dur;
        status_next = ST_ADDED;
      end
    end
  end

  // Request hold and task memory
  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      req_cmd <= cmd;
      req_dur <= duration;
    end
    if (wr_en) begin
      task_store[tail_ptr] <= req_dur;
    end
    if (ctl.rd_issue) begin
      rd_data <= task_store[head_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_limit <= TIME_LIMIT_RESET;
      head_ptr   <= '0;
      tail_ptr   <= '0;
      occupancy  <= '0;
      used_time  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        time_limit <= cfg_data;
      end
      if (wr_en) begin
        tail_ptr  <= (tail_ptr == PTR_LAST) ? '0 : tail_ptr + 1'b1;
        occupancy <= occupancy + 1'b1;
      end
      if (ctl.commit_pop) begin
        head_ptr  <= (head_ptr == PTR_LAST) ? '0 : head_ptr + 1'b1;
        occupancy <= occupancy - 1'b1;
      end
      if (commit) begin
        used_time <= used_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status    <= status_next;
      task_time <= task_next;
      time_used <= used_next;
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CNT_FULL)
    else $error("occupancy beyond queue depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (occupancy == '0 || occupancy == CNT_FULL) |-> head_ptr == tail_ptr)
    else $error("pointers disagree with occupancy");

  a_no_read_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.rd_issue |-> occupancy != '0)
    else $error("read issued on empty queue");

  a_commit_slot: assert property (@(posedge clk) disable iff (rst)
    commit |-> (!out_valid || out_ready))
    else $error("result overwritten before transfer");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("committed result not presented");
`endif

endmodule

[hw/rtl/budget_limited_task_fifo.sv]
// Top level of the budget-limited task FIFO.
`timescale 1ns / 1ps

// Circular queue of task durations with a running time budget. Each request
// on the input channel (cmd 0 add, cmd 1 execute oldest) yields exactly one
// result on the output channel: status, the executed duration (zero unless
// executed) and the queued total after the request. An add is refused with
// over-budget when the queued total plus the duration would exceed
// time_limit (checked at 17 bits, so no wrap), or with queue-full when
// QUEUE_DEPTH tasks are queued; the budget test wins when both apply.
// One request is in work at a time: an add or an execute on an empty queue
// is committed to the output register from the evaluate state, and the input
// is freed once it is; an execute that pops goes through a read state first,
// since the task memory has a registered read port. A finished
// result waits in the output register while the next request is taken in;
// a stalled output holds the sequencer once that next request is resolved.
// time_limit resets to 300 and is written through the cfg channel, which is
// always ready; write it only while the block is idle.
module budget_limited_task_fifo #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [btf_pkg::DUR_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic [btf_pkg::DUR_W-1:0]     duration,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [btf_pkg::STATUS_W-1:0]  status,
  output logic [btf_pkg::DUR_W-1:0]     task_time,
  output logic [btf_pkg::DUR_W-1:0]     time_used
);
  import btf_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t st;

  // The limit register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  // Sequence each request: capture, resolve, and for a pop wait on the read.
  btf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (ctl)
  );

  // Hold the queue, the pointers, the budget and the result register.
  btf_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .duration  (duration),
    .ctl       (ctl),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .task_time (task_time),
    .time_used (time_used)
  );

endmodule

[tb/sv/tb_budget_limited_task_fifo.sv]
// Self-checking testbench for the budget-limited task FIFO with its own queue model.
`timescale 1ns / 1ps

module tb_budget_limited_task_fifo;
  import btf_pkg::*;

  localparam int QUEUE_DEPTH  = 8;
  // Longest stretch without any transfer before the run is declared hung.
  // The deliberate output hold-off below (HOLD_OFF) and the random stalls are
  // far shorter, so this leaves a wide margin.
  localparam int QUIET_LIMIT  = 5000;
  localparam int HOLD_OFF     = 300;
  // Worst case is an execute with registered read, which passes through the
  // read state before it shows its result and frees the input.
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 10;
  localparam int PHASE_ITEMS   = 300;

  typedef struct packed {
    logic             cmd;
    logic [DUR_W-1:0] duration;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DUR_W-1:0]    task_time;
    logic [DUR_W-1:0]    time_used;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [DUR_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                cmd = CMD_ADD;
  logic [DUR_W-1:0]    duration = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [DUR_W-1:0]    task_time;
  logic [DUR_W-1:0]    time_used;

  // Stimulus and scoreboard storage
  request_t task_requests[$];
  outcome_t queued_outcomes[$];

  // Shadow copy of the task queue and budget
  logic [DUR_W-1:0] shadow_store[QUEUE_DEPTH];
  int               shadow_head = 0;
  int               shadow_tail = 0;
  int               shadow_count = 0;
  logic [DUR_W-1:0] shadow_used = '0;
  logic [DUR_W-1:0] shadow_limit = TIME_LIMIT_RESET;

  int send_idle_pct = 23;
  int recv_idle_pct = 84;
  int hold_left = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  budget_limited_task_fifo #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .duration  (duration),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .task_time (task_time),
    .time_used (time_used)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Resolve one accepted request against the shadow queue and return the
  // outcome the block must report for it.
  function automatic outcome_t resolve_request(request_t req);
    outcome_t         res;
    logic [DUR_W:0]   total;
    res.status    = ST_ADDED;
    res.task_time = '0;
    // Form the sum one bit wider so a wrap can never slip under the limit.
    total = {1'b0, shadow_used} + {1'b0, req.duration};
    if (req.cmd == CMD_ADD) begin
      // Budget test wins over the full test.
      if (total > {1'b0, shadow_limit}) begin
        res.status = ST_OVER_BUDGET;
      end else if (shadow_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        shadow_store[shadow_tail] = req.duration;
        shadow_tail = (shadow_tail + 1) % QUEUE_DEPTH;
        shadow_count++;
        shadow_used = total[DUR_W-1:0];
      end
    end else if (shadow_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.task_time = shadow_store[shadow_head];
      shadow_head = (shadow_head + 1) % QUEUE_DEPTH;
      shadow_count--;
      shadow_used = shadow_used - res.task_time;
      res.status = ST_EXECUTED;
    end
    res.time_used = shadow_used;
    return res;
  endfunction

  // Pick a duration: mostly small enough that the queue can fill before the
  // budget runs out, plus the extremes, full-range noise and near-limit values.
  function automatic logic [DUR_W-1:0] pick_duration(logic [DUR_W-1:0] limit);
    int lim;
    lim = limit;
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return DUR_W'($urandom);
      4:       return DUR_W'($urandom_range(lim, lim / 2));
      default: return DUR_W'($urandom_range(lim / 6 + 1));
    endcase
  endfunction

  task automatic push_request(logic req_cmd, logic [DUR_W-1:0] req_dur);
    request_t req;
    req.cmd      = req_cmd;
    req.duration = req_dur;
    task_requests.push_back(req);
  endtask

  // Queue random requests in bursts: add-heavy bursts fill the queue up to
  // full or over budget, execute-heavy bursts drain it down to empty, even bursts mix both.
  task automatic queue_random_requests(int count);
    int add_pct;
    int burst;
    while (count > 0) begin
      burst = $urandom_range(12, 1);
      case ($urandom_range(2))
        0:       add_pct = 80;
        1:       add_pct = 20;
        default: add_pct = 50;
      endcase
      repeat (burst) begin
        push_request(($urandom_range(99) < add_pct) ? CMD_ADD : CMD_EXEC,
                     pick_duration(shadow_limit));
        count--;
      end
    end
  endtask

  // Wait until every request is in and every outcome is out, then let the
  // block settle before touching the limit register.
  task automatic wait_for_idle();
    do @(negedge clk);
    while (task_requests.size() != 0 || in_valid || queued_outcomes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Called right after a rising edge; hold the write until it transfers.
  task automatic write_limit(logic [DUR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    shadow_limit = value;
    cfg_valid <= 1'b0;
  endtask

  // Request driver: predict on every input transfer, then present the next
  // queued request or idle. Valid stays up with a stable payload until taken.
  always @(posedge clk) begin
    request_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        req.cmd      = cmd;
        req.duration = duration;
        queued_outcomes.push_back(resolve_request(req));
      end
      if (!in_valid || in_ready) begin
        if (task_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = task_requests.pop_front();
          in_valid <= 1'b1;
          cmd      <= req.cmd;
          duration <= req.duration;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Outcome monitor: check each output transfer against the oldest prediction
  // and drive out_ready, with a long hold-off on request.
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (queued_outcomes.size() == 0) begin
          $error("unexpected outcome: status %0d task_time %0d time_used %0d",
                 status, task_time, time_used);
          mismatches++;
        end else begin
          want = queued_outcomes.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            mismatches++;
          end
          if (task_time !== want.task_time) begin
            $error("task_time: expected %0d, actual %0d", want.task_time, task_time);
            mismatches++;
          end
          if (time_used !== want.time_used) begin
            $error("time_used: expected %0d, actual %0d", want.time_used, time_used);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when no channel transfers for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [DUR_W-1:0] lim;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset limit of 300.
    push_request(CMD_EXEC, 16'd0);      // execute on empty queue
    push_request(CMD_ADD, 16'd0);       // zero duration
    push_request(CMD_ADD, 16'd300);     // lands exactly on the limit
    push_request(CMD_ADD, 16'd1);       // one over the limit
    push_request(CMD_ADD, 16'hFFFF);    // largest duration, over budget
    push_request(CMD_EXEC, 16'hFFFF);
    push_request(CMD_EXEC, 16'd0);
    // Fill to full within budget, wrapping the tail on the way in and the head on the way out.
    repeat (QUEUE_DEPTH) push_request(CMD_ADD, 16'd30);
    push_request(CMD_ADD, 16'd30);      // full, still within budget
    push_request(CMD_ADD, 16'd100);     // full and over budget: budget wins
    repeat (QUEUE_DEPTH) push_request(CMD_EXEC, 16'd0);

    // Widest limit: the sum must not wrap to admit a task.
    wait_for_idle();
    write_limit('1);
    @(negedge clk);
    push_request(CMD_ADD, 16'hFFFF);
    push_request(CMD_ADD, 16'd1);

    // Drop the limit below the queued total: adds refused while the task is kept; once popped, a zero add fits.
    wait_for_idle();
    write_limit('0);
    @(negedge clk);
    push_request(CMD_ADD, 16'd0);
    push_request(CMD_EXEC, 16'd0);
    push_request(CMD_ADD, 16'd0);
    push_request(CMD_ADD, 16'd1);
    push_request(CMD_EXEC, 16'd0);

    // Random phases: sender-light/receiver-heavy idling, then the reverse,
    // then none; the limit changes between phases, extremes included.
    for (int p = 0; p < 6; p++) begin
      wait_for_idle();
      case (p)
        0:       lim = 16'd1000;
        1:       lim = '1;
        2:       lim = '0;
        3:       lim = DUR_W'($urandom_range(4000, 50));
        4:       lim = TIME_LIMIT_RESET;
        default: lim = DUR_W'($urandom);
      endcase
      write_limit(lim);
      @(negedge clk);
      send_idle_pct = (p < 2) ? 23 : (p < 4) ? 84 : 0;
      recv_idle_pct = (p < 2) ? 84 : (p < 4) ? 23 : 0;
      // Hold off the output so the block backs up and stalls its input.
      if (p == 1) hold_left = HOLD_OFF;
      queue_random_requests(PHASE_ITEMS);
    end

    do @(negedge clk);
    while (task_requests.size() != 0 || in_valid || queued_outcomes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
